// File: hw/rtl/ddf_pkg.sv
// ----------------------------------------------------------------------------
// ddf_pkg
// Shared types, constants and place weights for the decimal display formatter.
// ----------------------------------------------------------------------------
package ddf_pkg;

  localparam int VAL_W    = 17;
  localparam int CHAR_W   = 6;
  localparam int DIGIT_W  = 4;
  localparam int PLACES   = 5;
  localparam int PLACE_W  = 3;

  typedef logic [VAL_W-1:0]   value_t;
  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [PLACE_W-1:0] place_t;

  localparam value_t MAX_SHOWN   = value_t'(99999);
  localparam char_t  ASCII_ZERO  = char_t'(48);
  localparam char_t  ASCII_SPACE = char_t'(32);
  localparam place_t FIRST_PLACE = place_t'(0);
  localparam place_t LAST_PLACE  = place_t'(PLACES - 1);

  // Result of one digit step.
  typedef struct packed {
    char_t  character;
    value_t rem;
    logic   seen;
    logic   last;
  } step_t;

  function automatic value_t place_weight(input place_t place);
    value_t w;
    unique case (place)
      3'd0:    w = value_t'(10000);
      3'd1:    w = value_t'(1000);
      3'd2:    w = value_t'(100);
      3'd3:    w = value_t'(10);
      default: w = value_t'(1);
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/ddf_in_buf.sv
// ----------------------------------------------------------------------------
// ddf_in_buf
// Input register: holds one accepted number, saturated to five digits.
// ----------------------------------------------------------------------------
module ddf_in_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ddf_pkg::value_t in_value,
  input  logic            take,
  output logic            buf_valid,
  output ddf_pkg::value_t buf_value
);

  logic            vld_r;
  logic            vld_nxt;
  ddf_pkg::value_t val_r;

  assign in_ready  = !vld_r || take;
  assign buf_valid = vld_r;
  assign buf_value = val_r;

  always_comb begin
    vld_nxt = vld_r && !take;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Clamp anything above five digits on the way in.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      val_r <= (in_value > ddf_pkg::MAX_SHOWN) ? ddf_pkg::MAX_SHOWN : in_value;
    end
  end

endmodule

// File: hw/rtl/ddf_digit.sv
// ----------------------------------------------------------------------------
// ddf_digit
// One decimal place: digit by parallel compares, remainder, blanking.
// ----------------------------------------------------------------------------
module ddf_digit (
  input  ddf_pkg::value_t rem,
  input  ddf_pkg::place_t place,
  input  logic            seen,
  output ddf_pkg::step_t  step
);

  always_comb begin
    ddf_pkg::value_t w;
    ddf_pkg::value_t thr;
    ddf_pkg::value_t sub;
    ddf_pkg::digit_t digit;
    logic            show;
    w     = ddf_pkg::place_weight(place);
    sub   = '0;
    digit = '0;
    // Highest multiple of the weight not above the remainder.
    for (int d = 1; d <= 9; d++) begin
      thr = ddf_pkg::value_t'(w * ddf_pkg::value_t'(d));
      if (rem >= thr) begin
        digit = ddf_pkg::digit_t'(d);
        sub   = thr;
      end
    end
    show           = seen || (digit != '0) || (place == ddf_pkg::LAST_PLACE);
    step.character = show ? ddf_pkg::char_t'(ddf_pkg::ASCII_ZERO + ddf_pkg::char_t'(digit))
                          : ddf_pkg::ASCII_SPACE;
    step.rem       = rem - sub;
    step.seen      = seen || (digit != '0);
    step.last      = (place == ddf_pkg::LAST_PLACE);
  end

endmodule

// File: hw/rtl/decimal_display_formatter.sv
// ----------------------------------------------------------------------------
// decimal_display_formatter
// Binary number to five ASCII characters with leading-zero blanking.
// ----------------------------------------------------------------------------
//  channel | ports                                | item
//  --------+--------------------------------------+--------------------------
//  in      | in_valid, in_ready, in_value         | one 17-bit number
//  out     | out_valid, out_ready, out_character, | one character, five per
//          | out_last_char                        | number, last one flagged
//
// One character per cycle when the output does not stall; the single digit unit
// works one place per cycle into the output register.
// The next number loads in the cycle its predecessor's last character is made.
// An accepted number passes the input register and digit state before output.
// Stalls on out_ready hold the output register and the digit state; reset
// empties the input register and the output register.
module decimal_display_formatter (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ddf_pkg::value_t in_value,
  output logic            out_valid,
  input  logic            out_ready,
  output ddf_pkg::char_t  out_character,
  output logic            out_last_char
);

  logic            buf_valid;
  ddf_pkg::value_t buf_value;
  logic            load;
  logic            out_adv;
  ddf_pkg::step_t  step;

  logic            act_r, act_nxt;
  ddf_pkg::value_t rem_r, rem_nxt;
  ddf_pkg::place_t place_r, place_nxt;
  logic            seen_r, seen_nxt;
  logic            out_vld_r, out_vld_nxt;
  ddf_pkg::char_t  char_r, char_nxt;
  logic            last_r, last_nxt;

  ddf_in_buf u_in_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_value  (in_value),
    .take      (load),
    .buf_valid (buf_valid),
    .buf_value (buf_value)
  );

  ddf_digit u_digit (
    .rem   (rem_r),
    .place (place_r),
    .seen  (seen_r),
    .step  (step)
  );

  assign out_adv = !out_vld_r || out_ready;
  assign load    = buf_valid && (!act_r || (out_adv && step.last));

  always_comb begin
    act_nxt     = act_r;
    rem_nxt     = rem_r;
    place_nxt   = place_r;
    seen_nxt    = seen_r;
    out_vld_nxt = out_vld_r && !out_ready;
    char_nxt    = char_r;
    last_nxt    = last_r;
    if (act_r && out_adv) begin
      out_vld_nxt = 1'b1;
      char_nxt    = step.character;
      last_nxt    = step.last;
      rem_nxt     = step.rem;
      seen_nxt    = step.seen;
      place_nxt   = ddf_pkg::place_t'(place_r + 1'b1);
      if (step.last) begin
        act_nxt = 1'b0;
      end
    end
    // Start the next number at the top place.
    if (load) begin
      act_nxt   = 1'b1;
      rem_nxt   = buf_value;
      place_nxt = ddf_pkg::FIRST_PLACE;
      seen_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      act_r     <= act_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    place_r <= place_nxt;
    seen_r  <= seen_nxt;
    char_r  <= char_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid     = out_vld_r;
  assign out_character = char_r;
  assign out_last_char = last_r;

endmodule
